@@ rtl/stc_pkg.sv @@
`default_nettype none
package stc_pkg;
    localparam int NUM_EDGES     = 3;
    localparam int NUM_REGS      = 6;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = $clog2(4 * NUM_REGS);
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    // Edge i runs from vertex i to the vertex that follows it in winding order.
    function automatic int next_vertex(input int i);
        begin
            return (i == NUM_EDGES - 1) ? 0 : i + 1;
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/stc_cfg.sv @@
`default_nettype none
module stc_cfg
    import stc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int DW         = COORD_BITS + 1,
    parameter int PW         = 2 * DW,
    parameter int SW         = PW + 1
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]        paddr,
    input  wire logic [APB_DATA_BITS-1:0]        pwdata,
    output logic      [APB_DATA_BITS-1:0]        prdata,
    output logic signed [COORD_BITS-1:0]         vx [NUM_EDGES],
    output logic signed [COORD_BITS-1:0]         vy [NUM_EDGES],
    output logic signed [DW-1:0]                 nx [NUM_EDGES],
    output logic signed [DW-1:0]                 ny [NUM_EDGES],
    output logic                                 area_neg,
    output logic                                 area_zero
);
    logic [COORD_BITS-1:0]  vert_reg [NUM_REGS];
    logic [REG_IDX_BITS-1:0] idx;
    logic                    idx_ok;
    logic signed [DW-1:0]    ex [NUM_EDGES];
    logic signed [DW-1:0]    ey [NUM_EDGES];
    logic signed [DW-1:0]    nx_reg [NUM_EDGES];
    logic signed [DW-1:0]    ny_reg [NUM_EDGES];
    logic signed [PW-1:0]    prod1_reg, prod2_reg;
    logic signed [SW-1:0]    area;
    logic                    area_neg_reg, area_zero_reg;

    assign idx    = paddr[APB_ADDR_BITS-1:2];
    assign idx_ok = (idx < REG_IDX_BITS'(NUM_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                vert_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && idx_ok)
        begin
            vert_reg[idx] <= pwdata[COORD_BITS-1:0];
        end
    end

    assign prdata = idx_ok ? APB_DATA_BITS'(vert_reg[idx]) : '0;

    always_comb
    begin
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            vx[i] = signed'(vert_reg[2 * i]);
            vy[i] = signed'(vert_reg[2 * i + 1]);
        end
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            ex[i] = DW'(vx[next_vertex(i)]) - DW'(vx[i]);
            ey[i] = DW'(vy[next_vertex(i)]) - DW'(vy[i]);
        end
    end

    // Twice the signed area is ey0*ex2 - ex0*ey2, since C - A = -(edge two).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod1_reg     <= '0;
            prod2_reg     <= '0;
            area_neg_reg  <= 1'b0;
            area_zero_reg <= 1'b1;
            for (int i = 0; i < NUM_EDGES; i++)
            begin
                nx_reg[i] <= '0;
                ny_reg[i] <= '0;
            end
        end
        else
        begin
            prod1_reg     <= ey[0] * ex[2];
            prod2_reg     <= ex[0] * ey[2];
            area_neg_reg  <= area[SW-1];
            area_zero_reg <= (area == '0);
            for (int i = 0; i < NUM_EDGES; i++)
            begin
                nx_reg[i] <= -ey[i];
                ny_reg[i] <= ex[i];
            end
        end
    end

    assign area      = SW'(prod1_reg) - SW'(prod2_reg);
    assign nx        = nx_reg;
    assign ny        = ny_reg;
    assign area_neg  = area_neg_reg;
    assign area_zero = area_zero_reg;
endmodule
`default_nettype wire

@@ rtl/stc_div.sv @@
`default_nettype none
module stc_div
    import stc_pkg::*;
#(
    parameter int RW        = 36,
    parameter int FRAC_BITS = 16,
    parameter int STEPS     = FRAC_BITS + 2
)
(
    input  wire logic                  clk,
    input  wire logic [RW-1:0]         r_in,
    input  wire logic [RW-1:0]         d_in,
    output logic      [FRAC_BITS:0]    q_out
);
    // Restoring division, one quotient bit per stage; the last bit rounds.
    logic [RW-1:0]    r_reg [STEPS];
    logic [RW-1:0]    d_reg [STEPS];
    logic [STEPS-1:0] q_reg [STEPS];
    logic [STEPS-1:0] q_inc;

    always_ff @(posedge clk)
    begin
        if (r_in >= d_in)
        begin
            r_reg[0] <= r_in - d_in;
            q_reg[0] <= STEPS'(1);
        end
        else
        begin
            r_reg[0] <= r_in;
            q_reg[0] <= '0;
        end
        d_reg[0] <= d_in;
        for (int k = 1; k < STEPS; k++)
        begin
            if ({r_reg[k-1][RW-2:0], 1'b0} >= d_reg[k-1])
            begin
                r_reg[k] <= {r_reg[k-1][RW-2:0], 1'b0} - d_reg[k-1];
                q_reg[k] <= {q_reg[k-1][STEPS-2:0], 1'b1};
            end
            else
            begin
                r_reg[k] <= {r_reg[k-1][RW-2:0], 1'b0};
                q_reg[k] <= {q_reg[k-1][STEPS-2:0], 1'b0};
            end
            d_reg[k] <= d_reg[k-1];
        end
    end

    assign q_inc = q_reg[STEPS-1] + STEPS'(1);
    assign q_out = q_inc[STEPS-1:1];
endmodule
`default_nettype wire

@@ rtl/segment_triangle_clipper_core.sv @@
`default_nettype none
// Throughput: one segment per cycle; busy stays low, since every stage advances each cycle.
// The depth is set by the pipelined divider that yields one quotient bit per stage.
// Reset (rst_n, asynchronous, active low) clears the vertex registers and all valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
module segment_triangle_clipper_core
    import stc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]     paddr,
    input  wire logic [APB_DATA_BITS-1:0]     pwdata,
    output logic      [APB_DATA_BITS-1:0]     prdata,
    output logic                              pready,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              done,
    output logic                              visible,
    output logic      [FRAC_BITS:0]           t_enter,
    output logic      [FRAC_BITS:0]           t_exit,
    output logic signed [COORD_BITS-1:0]      clip_start_x,
    output logic signed [COORD_BITS-1:0]      clip_start_y,
    output logic signed [COORD_BITS-1:0]      clip_end_x,
    output logic signed [COORD_BITS-1:0]      clip_end_y
);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 1;
    localparam int RW    = SW + 1;
    localparam int TW    = FRAC_BITS + 1;
    localparam int STEPS = FRAC_BITS + 2;
    localparam int MW    = TW + 1 + DW;

    logic signed [COORD_BITS-1:0] vx [NUM_EDGES];
    logic signed [COORD_BITS-1:0] vy [NUM_EDGES];
    logic signed [DW-1:0]         nx [NUM_EDGES];
    logic signed [DW-1:0]         ny [NUM_EDGES];
    logic                         area_neg, area_zero;

    stc_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .vx        (vx),
        .vy        (vy),
        .nx        (nx),
        .ny        (ny),
        .area_neg  (area_neg),
        .area_zero (area_zero)
    );

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // Stage 1: direction and start point relative to each edge's first vertex.
    logic                         v1_reg;
    logic signed [COORD_BITS-1:0] p0x1_reg, p0y1_reg;
    logic signed [DW-1:0]         dx1_reg, dy1_reg;
    logic signed [DW-1:0]         relx1_reg [NUM_EDGES];
    logic signed [DW-1:0]         rely1_reg [NUM_EDGES];

    always_ff @(posedge clk)
    begin
        p0x1_reg <= start_x;
        p0y1_reg <= start_y;
        dx1_reg  <= DW'(end_x) - DW'(start_x);
        dy1_reg  <= DW'(end_y) - DW'(start_y);
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            relx1_reg[i] <= DW'(start_x) - DW'(vx[i]);
            rely1_reg[i] <= DW'(start_y) - DW'(vy[i]);
        end
    end

    // Stage 2: products for num = n.(P0 - Vi) and den = n.d.
    logic                         v2_reg;
    logic signed [COORD_BITS-1:0] p0x2_reg, p0y2_reg;
    logic signed [DW-1:0]         dx2_reg, dy2_reg;
    logic signed [PW-1:0]         pn1_reg [NUM_EDGES];
    logic signed [PW-1:0]         pn2_reg [NUM_EDGES];
    logic signed [PW-1:0]         pd1_reg [NUM_EDGES];
    logic signed [PW-1:0]         pd2_reg [NUM_EDGES];

    always_ff @(posedge clk)
    begin
        p0x2_reg <= p0x1_reg;
        p0y2_reg <= p0y1_reg;
        dx2_reg  <= dx1_reg;
        dy2_reg  <= dy1_reg;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            pn1_reg[i] <= nx[i] * relx1_reg[i];
            pn2_reg[i] <= ny[i] * rely1_reg[i];
            pd1_reg[i] <= nx[i] * dx1_reg;
            pd2_reg[i] <= ny[i] * dy1_reg;
        end
    end

    // Stage 3: sums; a clockwise triangle flips the normals, hence both signs.
    logic                         v3_reg, ok3_reg;
    logic signed [COORD_BITS-1:0] p0x3_reg, p0y3_reg;
    logic signed [DW-1:0]         dx3_reg, dy3_reg;
    logic signed [SW-1:0]         num3_reg [NUM_EDGES];
    logic signed [SW-1:0]         den3_reg [NUM_EDGES];
    logic signed [SW-1:0]         num_sum [NUM_EDGES];
    logic signed [SW-1:0]         den_sum [NUM_EDGES];

    always_comb
    begin
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            num_sum[i] = SW'(pn1_reg[i]) + SW'(pn2_reg[i]);
            den_sum[i] = SW'(pd1_reg[i]) + SW'(pd2_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        p0x3_reg <= p0x2_reg;
        p0y3_reg <= p0y2_reg;
        dx3_reg  <= dx2_reg;
        dy3_reg  <= dy2_reg;
        ok3_reg  <= !area_zero;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            num3_reg[i] <= area_neg ? -num_sum[i] : num_sum[i];
            den3_reg[i] <= area_neg ? -den_sum[i] : den_sum[i];
        end
    end

    // Stage 4: classify each edge as entering, exiting, ignored or rejecting.
    logic                         v4_reg, ok4_reg;
    logic signed [COORD_BITS-1:0] p0x4_reg, p0y4_reg;
    logic signed [DW-1:0]         dx4_reg, dy4_reg;
    logic [NUM_EDGES-1:0]         ent4_reg, ext4_reg;
    logic [RW-1:0]                r4_reg [NUM_EDGES];
    logic [RW-1:0]                d4_reg [NUM_EDGES];
    logic [NUM_EDGES-1:0]         rej, ent, ext;
    logic [RW-1:0]                r_c [NUM_EDGES];
    logic [RW-1:0]                d_c [NUM_EDGES];
    logic signed [SW-1:0]         neg_num, neg_den;

    always_comb
    begin
        neg_num = '0;
        neg_den = '0;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            rej[i]  = 1'b0;
            ent[i]  = 1'b0;
            ext[i]  = 1'b0;
            r_c[i]  = '0;
            d_c[i]  = RW'(1);
            neg_num = -num3_reg[i];
            neg_den = -den3_reg[i];
            if (den3_reg[i] == '0)
            begin
                rej[i] = num3_reg[i][SW-1];
            end
            else if (!den3_reg[i][SW-1])
            begin
                if (num3_reg[i][SW-1])
                begin
                    if (neg_num > den3_reg[i])
                    begin
                        rej[i] = 1'b1;
                    end
                    else
                    begin
                        ent[i] = 1'b1;
                        r_c[i] = RW'(unsigned'(neg_num));
                        d_c[i] = RW'(unsigned'(den3_reg[i]));
                    end
                end
            end
            else
            begin
                if (num3_reg[i][SW-1])
                begin
                    rej[i] = 1'b1;
                end
                else if (num3_reg[i] < neg_den)
                begin
                    ext[i] = 1'b1;
                    r_c[i] = RW'(unsigned'(num3_reg[i]));
                    d_c[i] = RW'(unsigned'(neg_den));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p0x4_reg <= p0x3_reg;
        p0y4_reg <= p0y3_reg;
        dx4_reg  <= dx3_reg;
        dy4_reg  <= dy3_reg;
        ok4_reg  <= ok3_reg && (rej == '0);
        ent4_reg <= ent;
        ext4_reg <= ext;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            r4_reg[i] <= r_c[i];
            d4_reg[i] <= d_c[i];
        end
    end

    // Divider lanes, one per edge, with the request's side data alongside.
    logic [FRAC_BITS:0] q [NUM_EDGES];

    for (genvar g = 0; g < NUM_EDGES; g++)
    begin : g_div
        stc_div #(.RW(RW), .FRAC_BITS(FRAC_BITS)) u_div (
            .clk   (clk),
            .r_in  (r4_reg[g]),
            .d_in  (d4_reg[g]),
            .q_out (q[g])
        );
    end

    logic [STEPS-1:0]             vd_reg;
    logic                         okd_reg  [STEPS];
    logic [NUM_EDGES-1:0]         entd_reg [STEPS];
    logic [NUM_EDGES-1:0]         extd_reg [STEPS];
    logic signed [COORD_BITS-1:0] p0xd_reg [STEPS];
    logic signed [COORD_BITS-1:0] p0yd_reg [STEPS];
    logic signed [DW-1:0]         dxd_reg  [STEPS];
    logic signed [DW-1:0]         dyd_reg  [STEPS];

    always_ff @(posedge clk)
    begin
        okd_reg[0]  <= ok4_reg;
        entd_reg[0] <= ent4_reg;
        extd_reg[0] <= ext4_reg;
        p0xd_reg[0] <= p0x4_reg;
        p0yd_reg[0] <= p0y4_reg;
        dxd_reg[0]  <= dx4_reg;
        dyd_reg[0]  <= dy4_reg;
        for (int k = 1; k < STEPS; k++)
        begin
            okd_reg[k]  <= okd_reg[k-1];
            entd_reg[k] <= entd_reg[k-1];
            extd_reg[k] <= extd_reg[k-1];
            p0xd_reg[k] <= p0xd_reg[k-1];
            p0yd_reg[k] <= p0yd_reg[k-1];
            dxd_reg[k]  <= dxd_reg[k-1];
            dyd_reg[k]  <= dyd_reg[k-1];
        end
    end

    // Select stage: largest enter, smallest exit, final visibility.
    logic                         v5_reg, vis5_reg;
    logic [TW-1:0]                te5_reg, tl5_reg;
    logic signed [COORD_BITS-1:0] p0x5_reg, p0y5_reg;
    logic signed [DW-1:0]         dx5_reg, dy5_reg;
    logic [TW-1:0]                te_c, tl_c;

    always_comb
    begin
        te_c = '0;
        tl_c = TW'(1) << FRAC_BITS;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            if (entd_reg[STEPS-1][i] && (q[i] > te_c))
            begin
                te_c = q[i];
            end
            if (extd_reg[STEPS-1][i] && (q[i] < tl_c))
            begin
                tl_c = q[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vis5_reg <= okd_reg[STEPS-1] && (te_c <= tl_c);
        te5_reg  <= te_c;
        tl5_reg  <= tl_c;
        p0x5_reg <= p0xd_reg[STEPS-1];
        p0y5_reg <= p0yd_reg[STEPS-1];
        dx5_reg  <= dxd_reg[STEPS-1];
        dy5_reg  <= dyd_reg[STEPS-1];
    end

    // Multiply stage: t times direction.
    logic                         v6_reg, vis6_reg;
    logic [TW-1:0]                te6_reg, tl6_reg;
    logic signed [COORD_BITS-1:0] p0x6_reg, p0y6_reg;
    logic signed [MW-1:0]         mex_reg, mey_reg, mlx_reg, mly_reg;

    always_ff @(posedge clk)
    begin
        vis6_reg <= vis5_reg;
        te6_reg  <= te5_reg;
        tl6_reg  <= tl5_reg;
        p0x6_reg <= p0x5_reg;
        p0y6_reg <= p0y5_reg;
        mex_reg  <= signed'({1'b0, te5_reg}) * dx5_reg;
        mey_reg  <= signed'({1'b0, te5_reg}) * dy5_reg;
        mlx_reg  <= signed'({1'b0, tl5_reg}) * dx5_reg;
        mly_reg  <= signed'({1'b0, tl5_reg}) * dy5_reg;
    end

    // Output stage: round to nearest (ties up) and add the start point.
    localparam logic signed [MW-1:0] HALF = MW'(1) << (FRAC_BITS - 1);

    logic signed [MW-1:0] sex, sey, slx, sly;

    assign sex = (mex_reg + HALF) >>> FRAC_BITS;
    assign sey = (mey_reg + HALF) >>> FRAC_BITS;
    assign slx = (mlx_reg + HALF) >>> FRAC_BITS;
    assign sly = (mly_reg + HALF) >>> FRAC_BITS;

    logic                         done_reg, vis_reg;
    logic [TW-1:0]                te_reg, tl_reg;
    logic signed [COORD_BITS-1:0] csx_reg, csy_reg, cex_reg, cey_reg;

    always_ff @(posedge clk)
    begin
        vis_reg <= vis6_reg;
        te_reg  <= vis6_reg ? te6_reg : '0;
        tl_reg  <= vis6_reg ? tl6_reg : '0;
        csx_reg <= vis6_reg ? p0x6_reg + sex[COORD_BITS-1:0] : '0;
        csy_reg <= vis6_reg ? p0y6_reg + sey[COORD_BITS-1:0] : '0;
        cex_reg <= vis6_reg ? p0x6_reg + slx[COORD_BITS-1:0] : '0;
        cey_reg <= vis6_reg ? p0y6_reg + sly[COORD_BITS-1:0] : '0;
    end

    // Valid bits travel with the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vd_reg   <= '0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            vd_reg   <= {vd_reg[STEPS-2:0], v4_reg};
            v5_reg   <= vd_reg[STEPS-1];
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    assign done         = done_reg;
    assign visible      = vis_reg;
    assign t_enter      = te_reg;
    assign t_exit       = tl_reg;
    assign clip_start_x = csx_reg;
    assign clip_start_y = csy_reg;
    assign clip_end_x   = cex_reg;
    assign clip_end_y   = cey_reg;
endmodule
`default_nettype wire

@@ tb/sv/tb_segment_triangle_clipper_core.sv @@
`timescale 1ns / 1ps
module tb_segment_triangle_clipper_core;
    import stc_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int LATENCY = FB + 9;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [FB:0] T_ONE = (FB + 1)'(1) << FB;

    localparam int REG_A_X = 0;
    localparam int REG_A_Y = 1;
    localparam int REG_B_X = 2;
    localparam int REG_B_Y = 3;
    localparam int REG_C_X = 4;
    localparam int REG_C_Y = 5;

    typedef struct packed {
        logic        visible;
        logic [FB:0] t_enter;
        logic [FB:0] t_exit;
        logic [CB-1:0] csx;
        logic [CB-1:0] csy;
        logic [CB-1:0] cex;
        logic [CB-1:0] cey;
    } clip_t;

    typedef struct {
        logic [CB-1:0] sx, sy, ex, ey;
        bit            has_known;
        clip_t         known;
    } seg_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;
    logic start = 0;
    logic busy;
    logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic done, visible;
    logic [FB:0] t_enter, t_exit;
    logic signed [CB-1:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;

    segment_triangle_clipper_core i_dut (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    logic signed [CB-1:0] tri_v [NUM_REGS];
    clip_t expected_clips[$];
    int errors = 0;
    int cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Restoring division: round(r/d * 2^FB), ties up.
    function automatic logic [FB:0] quantize_t(input longint unsigned r,
                                               input longint unsigned d);
        longint unsigned q;
        q = 0;
        if (r >= d)
        begin
            q = 1;
            r -= d;
        end
        for (int i = 0; i < FB + 1; i++)
        begin
            r <<= 1;
            q <<= 1;
            if (r >= d)
            begin
                q |= 1;
                r -= d;
            end
        end
        return (FB + 1)'((q + 1) >> 1);
    endfunction

    function automatic longint round_frac(input longint v);
        v += (1 << (FB - 1));
        if (v >= 0)
            return v >>> FB;
        return -(((-v) + (1 << FB) - 1) >>> FB);
    endfunction

    function automatic clip_t clip_segment(input logic signed [CB-1:0] sx,
                                           input logic signed [CB-1:0] sy,
                                           input logic signed [CB-1:0] ex,
                                           input logic signed [CB-1:0] ey);
        longint vx[3], vy[3];
        longint dx, dy, area, nx, ny, num, den, edx, edy;
        longint unsigned te, tl, q;
        bit ok;
        int j;
        clip_t r;
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = tri_v[2*i];
            vy[i] = tri_v[2*i+1];
        end
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        te = 0;
        tl = T_ONE;
        area = (vx[1]-vx[0])*(vy[2]-vy[0]) - (vy[1]-vy[0])*(vx[2]-vx[0]);
        ok = (area != 0);
        for (int i = 0; i < 3 && ok; i++)
        begin
            j = (i == 2) ? 0 : i + 1;
            edx = vx[j] - vx[i];
            edy = vy[j] - vy[i];
            if (area > 0)
            begin
                nx = -edy;
                ny = edx;
            end
            else
            begin
                nx = edy;
                ny = -edx;
            end
            num = nx*(longint'(sx) - vx[i]) + ny*(longint'(sy) - vy[i]);
            den = nx*dx + ny*dy;
            if (den == 0)
            begin
                if (num < 0)
                    ok = 0;
            end
            else if (den > 0)
            begin
                if (num < 0)
                begin
                    if (-num > den)
                        ok = 0;
                    else
                    begin
                        q = quantize_t(-num, den);
                        if (q > te)
                            te = q;
                    end
                end
            end
            else
            begin
                if (num < 0)
                    ok = 0;
                else if (num < -den)
                begin
                    q = quantize_t(num, -den);
                    if (q < tl)
                        tl = q;
                end
            end
        end
        if (ok && te > tl)
            ok = 0;
        r = '0;
        if (ok)
        begin
            r.visible = 1;
            r.t_enter = (FB + 1)'(te);
            r.t_exit  = (FB + 1)'(tl);
            r.csx = CB'(longint'(sx) + round_frac(longint'(te) * dx));
            r.csy = CB'(longint'(sy) + round_frac(longint'(te) * dy));
            r.cex = CB'(longint'(sx) + round_frac(longint'(tl) * dx));
            r.cey = CB'(longint'(sy) + round_frac(longint'(tl) * dy));
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        clip_t got, exp_c;
        if (rst_n && done)
        begin
            got = {visible, t_enter, t_exit, clip_start_x, clip_start_y,
                   clip_end_x, clip_end_y};
            if (expected_clips.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                exp_c = expected_clips.pop_front();
                if (got.visible !== exp_c.visible)
                    report_mismatch($sformatf("visible %0b exp %0b", got.visible,
                                              exp_c.visible));
                if (got.t_enter !== exp_c.t_enter)
                    report_mismatch($sformatf("t_enter %0d exp %0d", got.t_enter,
                                              exp_c.t_enter));
                if (got.t_exit !== exp_c.t_exit)
                    report_mismatch($sformatf("t_exit %0d exp %0d", got.t_exit,
                                              exp_c.t_exit));
                if (got.csx !== exp_c.csx || got.csy !== exp_c.csy)
                    report_mismatch($sformatf("clip start %0d,%0d exp %0d,%0d",
                        $signed(got.csx), $signed(got.csy),
                        $signed(exp_c.csx), $signed(exp_c.csy)));
                if (got.cex !== exp_c.cex || got.cey !== exp_c.cey)
                    report_mismatch($sformatf("clip end %0d,%0d exp %0d,%0d",
                        $signed(got.cex), $signed(got.cey),
                        $signed(exp_c.cex), $signed(exp_c.cey)));
            end
        end
    end

    task automatic write_vertex(input int idx, input logic signed [CB-1:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= APB_ADDR_BITS'(idx * 4);
        pwdata  <= {{(APB_DATA_BITS-CB){val[CB-1]}}, val};
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        if (idx < NUM_REGS)
            tri_v[idx] = val;
        @(posedge clk);
    endtask

    task automatic set_triangle(input int ax, ay, bx, by, cx, cy);
        write_vertex(REG_A_X, CB'(ax));
        write_vertex(REG_A_Y, CB'(ay));
        write_vertex(REG_B_X, CB'(bx));
        write_vertex(REG_B_Y, CB'(by));
        write_vertex(REG_C_X, CB'(cx));
        write_vertex(REG_C_Y, CB'(cy));
    endtask

    task automatic drain();
        while (expected_clips.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Drives one request; the known result, if given, overrides the predictor.
    task automatic send_segment(input logic [CB-1:0] sx, sy, ex, ey,
                                input bit has_known, input clip_t known);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1;
        start_x <= sx;
        start_y <= sy;
        end_x   <= ex;
        end_y   <= ey;
        do @(posedge clk); while (busy);
        expected_clips.insert(expected_clips.size(),
                              has_known ? known : clip_segment(sx, sy, ex, ey));
    endtask

    function automatic logic [CB-1:0] rand_coord(input int span);
        if ($urandom_range(0, 9) == 0)
            return CB'($urandom());
        return CB'($urandom_range(0, 2*span) - span);
    endfunction

    seg_row_t directed[$];
    clip_t hidden;

    task automatic add_row(input logic [CB-1:0] sx, sy, ex, ey,
                           input bit has_known, input clip_t known);
        seg_row_t row;
        row.sx        = sx;
        row.sy        = sy;
        row.ex        = ex;
        row.ey        = ey;
        row.has_known = has_known;
        row.known     = known;
        directed.insert(directed.size(), row);
    endtask

    initial
    begin
        hidden = '0;
        for (int i = 0; i < NUM_REGS; i++)
            tri_v[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Registers still zero: degenerate triangle, nothing is visible.
        add_row(16'sd0, 16'sd0, 16'sd10, 16'sd10, 1, hidden);
        add_row(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1, hidden);
        foreach (directed[k])
            send_segment(directed[k].sx, directed[k].sy, directed[k].ex,
                         directed[k].ey, directed[k].has_known, directed[k].known);
        start <= 0;
        drain();

        set_triangle(0, 0, 100, 0, 0, 100);
        directed.delete();
        // Fully inside, fully crossing, parallel inside and outside, point cases.
        add_row(16'sd10, 16'sd10, 16'sd20, 16'sd20, 1,
            '{1'b1, 17'd0, T_ONE, 16'sd10, 16'sd10, 16'sd20, 16'sd20});
        add_row(16'sd5, 16'sd5, 16'sd5, 16'sd5, 1,
            '{1'b1, 17'd0, T_ONE, 16'sd5, 16'sd5, 16'sd5, 16'sd5});
        add_row(-16'sd5, -16'sd5, -16'sd5, -16'sd5, 1, hidden);
        add_row(-16'sd50, 16'sd10, 16'sd150, 16'sd10, 0, hidden);
        add_row(16'sd10, -16'sd5, 16'sd50, -16'sd5, 1, hidden);
        add_row(16'sd10, 16'sd0, 16'sd50, 16'sd0, 0, hidden);
        add_row(16'sd200, 16'sd200, 16'sd300, 16'sd300, 1, hidden);
        add_row(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0, hidden);
        add_row(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 0, hidden);
        add_row(16'sd0, 16'sd0, 16'sd100, 16'sd0, 0, hidden);
        add_row(16'sd50, 16'sd50, 16'sd50, 16'sd50, 0, hidden);
        add_row(-16'sd10, 16'sd60, 16'sd60, -16'sd10, 0, hidden);
        foreach (directed[k])
            send_segment(directed[k].sx, directed[k].sy, directed[k].ex,
                         directed[k].ey, directed[k].has_known, directed[k].known);
        start <= 0;
        drain();

        // Clockwise winding at the coordinate extremes.
        set_triangle(-32768, -32768, -32768, 32767, 32767, -32768);
        for (int i = 0; i < 8; i++)
            send_segment(CB'($urandom()), CB'($urandom()), CB'($urandom()),
                         CB'($urandom()), 0, hidden);
        start <= 0;
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            int span;
            span = (ph < 3) ? 200 : 32767;
            if (ph == 2)
                set_triangle(10, 10, 20, 20, 30, 30);
            else
                set_triangle(rand_coord(span), rand_coord(span), rand_coord(span),
                             rand_coord(span), rand_coord(span), rand_coord(span));
            for (int i = 0; i < 65; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    logic [CB-1:0] px, py;
                    px = rand_coord(span);
                    py = rand_coord(span);
                    send_segment(px, py, px, py, 0, hidden);
                end
                else
                    send_segment(rand_coord(span), rand_coord(span), rand_coord(span),
                                 rand_coord(span), 0, hidden);
            end
            start <= 0;
            drain();
        end
        // An out-of-range register index must not disturb the triangle.
        write_vertex(NUM_REGS + 1, 16'sd1234);
        for (int i = 0; i < 5; i++)
            send_segment(rand_coord(300), rand_coord(300), rand_coord(300),
                         rand_coord(300), 0, hidden);
        start <= 0;
        drain();

        if (errors == 0 && expected_clips.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
